### hdl/overlap_refcount_event_tracker_assert.svh
// Assertion macros for the overlap tracker RTL; ort_ctrl includes them.
// Used by files that assert through a bare-name include; needs no package.
`ifndef OVERLAP_REFCOUNT_EVENT_TRACKER_ASSERT_SVH
`define OVERLAP_REFCOUNT_EVENT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define ORT_ASSERT_HOLDS(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ORT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ort_pkg.sv
// Shared types and constants for the overlap tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ort_pkg;

    localparam int unsigned OBJ_W = 16;
    localparam int unsigned IDX_W = 8;
    localparam int unsigned CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int unsigned PAIR_SLOTS_DEF   = 64;
    localparam int unsigned OBJECT_SLOTS_DEF = 32;

    // Operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_EXIT  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PAIR_FULL = 2'd1;
    localparam logic [1:0] ST_OBJ_FULL  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    typedef struct packed {
        logic             op;
        logic [OBJ_W-1:0] other_object;
        logic             other_is_area;
        logic [IDX_W-1:0] other_shape_index;
        logic [IDX_W-1:0] self_shape_index;
    } t_item;

    typedef struct packed {
        logic [1:0]       event_res;
        logic             event_to_area;
        logic [OBJ_W-1:0] event_object;
        logic [IDX_W-1:0] event_other_index;
        logic [IDX_W-1:0] event_self_index;
        logic             refresh_body;
        logic [1:0]       status;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic             is_area;
        logic [OBJ_W-1:0] object;
        logic [IDX_W-1:0] other_idx;
        logic [IDX_W-1:0] self_idx;
        logic [CNT_W-1:0] count;
    } t_pair_entry;

    typedef struct packed {
        logic             valid;
        logic [OBJ_W-1:0] object;
        logic [CNT_W-1:0] count;
    } t_obj_entry;

    // Sequencer to table
    typedef struct packed {
        logic start;
        logic wr_en;
    } t_tbl_cmd;

    // Table to sequencer
    typedef struct packed {
        logic        clr_busy;
        logic        done;
        logic        hit;
        logic        free;
        t_pair_entry hit_entry;
    } t_pair_stat;

    typedef struct packed {
        logic       clr_busy;
        logic       done;
        logic       hit;
        logic       free;
        t_obj_entry hit_entry;
    } t_obj_stat;

endpackage

### hdl/ort_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
// Payload type is set by the instantiating code (items or results from ort_pkg).
`timescale 1ns / 1ps

interface ort_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/ort_pair_tbl.sv
// Pair table: dual-port synchronous memory with clear sweep and linear key scan.
// Depends on ort_pkg.
`timescale 1ns / 1ps

module ort_pair_tbl #(
    parameter int unsigned SLOTS = ort_pkg::PAIR_SLOTS_DEF,
    localparam int unsigned AW = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ort_pkg::t_tbl_cmd  i_cmd,
    input  ort_pkg::t_item     i_key,
    input  logic [AW-1:0]      i_waddr,
    input  ort_pkg::t_pair_entry i_wdata,
    output ort_pkg::t_pair_stat  o_stat,
    output logic [AW-1:0]      o_hit_addr,
    output logic [AW-1:0]      o_free_addr
);
    import ort_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    t_pair_entry   r_mem [SLOTS];
    t_pair_entry   r_rd_data;
    t_pair_entry   r_hit_entry;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_scan_act;
    logic [AW-1:0] r_scan_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_addr;
    logic          r_done;
    logic          r_hit;
    logic          r_free;
    logic [AW-1:0] r_hit_addr;
    logic [AW-1:0] r_free_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_pair_entry   mem_wdata;
    logic          key_match;

    // Write port: clear sweep has priority over sequencer writes
    assign mem_we    = r_clr_busy | i_cmd.wr_en;
    assign mem_waddr = r_clr_busy ? r_clr_addr : i_waddr;
    assign mem_wdata = r_clr_busy ? '0 : i_wdata;

    assign key_match = r_rd_data.valid
                     && (r_rd_data.object    == i_key.other_object)
                     && (r_rd_data.other_idx == i_key.other_shape_index)
                     && (r_rd_data.self_idx  == i_key.self_shape_index);

    // Memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_scan_addr];
    end

    // Clear sweep and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_scan_act  <= 1'b0;
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_done      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                r_scan_act  <= 1'b1;
                r_scan_addr <= '0;
            end else if (r_scan_act) begin
                if (r_scan_addr == LAST) begin
                    r_scan_act <= 1'b0;
                end else begin
                    r_scan_addr <= r_scan_addr + AW'(1);
                end
            end
            r_rd_vld <= r_scan_act;
            if (i_cmd.start) begin
                r_done <= 1'b0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_vld) begin
                if (key_match) begin
                    r_hit <= 1'b1;
                end
                if (!r_rd_data.valid) begin
                    r_free <= 1'b1;
                end
                if (r_rd_addr == LAST) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // First match and first free slot
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_scan_addr;
        if (r_rd_vld && !i_cmd.start) begin
            if (key_match && !r_hit) begin
                r_hit_addr  <= r_rd_addr;
                r_hit_entry <= r_rd_data;
            end
            if (!r_rd_data.valid && !r_free) begin
                r_free_addr <= r_rd_addr;
            end
        end
    end

    assign o_stat = '{clr_busy: r_clr_busy, done: r_done, hit: r_hit, free: r_free,
                      hit_entry: r_hit_entry};
    assign o_hit_addr  = r_hit_addr;
    assign o_free_addr = r_free_addr;

endmodule

### hdl/ort_obj_tbl.sv
// Object table: dual-port synchronous memory with clear sweep and object scan.
// Depends on ort_pkg.
`timescale 1ns / 1ps

module ort_obj_tbl #(
    parameter int unsigned SLOTS = ort_pkg::OBJECT_SLOTS_DEF,
    localparam int unsigned AW = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ort_pkg::t_tbl_cmd  i_cmd,
    input  ort_pkg::t_item     i_key,
    input  logic [AW-1:0]      i_waddr,
    input  ort_pkg::t_obj_entry i_wdata,
    output ort_pkg::t_obj_stat  o_stat,
    output logic [AW-1:0]      o_hit_addr,
    output logic [AW-1:0]      o_free_addr
);
    import ort_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    t_obj_entry    r_mem [SLOTS];
    t_obj_entry    r_rd_data;
    t_obj_entry    r_hit_entry;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_scan_act;
    logic [AW-1:0] r_scan_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_addr;
    logic          r_done;
    logic          r_hit;
    logic          r_free;
    logic [AW-1:0] r_hit_addr;
    logic [AW-1:0] r_free_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_obj_entry    mem_wdata;
    logic          key_match;

    // Write port: clear sweep has priority over sequencer writes
    assign mem_we    = r_clr_busy | i_cmd.wr_en;
    assign mem_waddr = r_clr_busy ? r_clr_addr : i_waddr;
    assign mem_wdata = r_clr_busy ? '0 : i_wdata;

    assign key_match = r_rd_data.valid && (r_rd_data.object == i_key.other_object);

    // Memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_scan_addr];
    end

    // Clear sweep and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_scan_act  <= 1'b0;
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_done      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                r_scan_act  <= 1'b1;
                r_scan_addr <= '0;
            end else if (r_scan_act) begin
                if (r_scan_addr == LAST) begin
                    r_scan_act <= 1'b0;
                end else begin
                    r_scan_addr <= r_scan_addr + AW'(1);
                end
            end
            r_rd_vld <= r_scan_act;
            if (i_cmd.start) begin
                r_done <= 1'b0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_vld) begin
                if (key_match) begin
                    r_hit <= 1'b1;
                end
                if (!r_rd_data.valid) begin
                    r_free <= 1'b1;
                end
                if (r_rd_addr == LAST) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // First match and first free slot
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_scan_addr;
        if (r_rd_vld && !i_cmd.start) begin
            if (key_match && !r_hit) begin
                r_hit_addr  <= r_rd_addr;
                r_hit_entry <= r_rd_data;
            end
            if (!r_rd_data.valid && !r_free) begin
                r_free_addr <= r_rd_addr;
            end
        end
    end

    assign o_stat = '{clr_busy: r_clr_busy, done: r_done, hit: r_hit, free: r_free,
                      hit_entry: r_hit_entry};
    assign o_hit_addr  = r_hit_addr;
    assign o_free_addr = r_free_addr;

endmodule

### hdl/ort_ctrl.sv
// Sequencer: takes items, starts both table scans, decides the update, writes back
// and holds the result register. Depends on ort_pkg, ort_chan_if and the assert macros.
`timescale 1ns / 1ps
`include "overlap_refcount_event_tracker_assert.svh"

module ort_ctrl #(
    parameter int unsigned PAIR_SLOTS   = ort_pkg::PAIR_SLOTS_DEF,
    parameter int unsigned OBJECT_SLOTS = ort_pkg::OBJECT_SLOTS_DEF,
    localparam int unsigned PAW = $clog2(PAIR_SLOTS),
    localparam int unsigned OAW = $clog2(OBJECT_SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ort_chan_if.sink             i_item,
    ort_chan_if.source           o_res,
    output ort_pkg::t_item       o_key,
    output ort_pkg::t_tbl_cmd    o_pair_cmd,
    output logic [PAW-1:0]       o_pair_waddr,
    output ort_pkg::t_pair_entry o_pair_wdata,
    input  ort_pkg::t_pair_stat  i_pair_stat,
    input  logic [PAW-1:0]       i_pair_hit_addr,
    input  logic [PAW-1:0]       i_pair_free_addr,
    output ort_pkg::t_tbl_cmd    o_obj_cmd,
    output logic [OAW-1:0]       o_obj_waddr,
    output ort_pkg::t_obj_entry  o_obj_wdata,
    input  ort_pkg::t_obj_stat   i_obj_stat,
    input  logic [OAW-1:0]       i_obj_hit_addr,
    input  logic [OAW-1:0]       i_obj_free_addr
);
    import ort_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_item      r_item;
    t_result    r_out;
    t_result    n_res;
    logic       r_out_vld;
    logic       accept;
    logic       load;
    logic       pair_we;
    logic       obj_we;
    logic       exit_zero;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
    endfunction

    assign accept = i_item.valid && i_item.ready;
    assign load   = (r_state == S_WRITE) && (!r_out_vld || o_res.ready);

    assign i_item.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_out_vld;
    assign o_res.data   = r_out;
    assign o_key        = r_item;

    assign o_pair_cmd = '{start: accept, wr_en: pair_we};
    assign o_obj_cmd  = '{start: accept, wr_en: obj_we};

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (!i_pair_stat.clr_busy && !i_obj_stat.clr_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_pair_stat.done && i_obj_stat.done) n_state = S_WRITE;
            end
            S_WRITE: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Update decision from the scan results
    always_comb begin
        n_res        = '0;
        pair_we      = 1'b0;
        o_pair_waddr = i_pair_hit_addr;
        o_pair_wdata = i_pair_stat.hit_entry;
        obj_we       = 1'b0;
        o_obj_waddr  = i_obj_hit_addr;
        o_obj_wdata  = i_obj_stat.hit_entry;
        exit_zero    = 1'b1;
        if (r_item.op == OP_ADD) begin
            if (i_pair_stat.hit) begin
                // known pair: refresh type, count up with saturation
                pair_we              = 1'b1;
                o_pair_wdata.is_area = r_item.other_is_area;
                o_pair_wdata.count   = sat_inc(i_pair_stat.hit_entry.count);
            end else if (!i_pair_stat.free) begin
                n_res.status = ST_PAIR_FULL;
            end else if (!i_obj_stat.hit && !i_obj_stat.free) begin
                n_res.status = ST_OBJ_FULL;
            end else begin
                // new pair, shape entered
                pair_we      = 1'b1;
                o_pair_waddr = i_pair_free_addr;
                o_pair_wdata = '{valid: 1'b1, is_area: r_item.other_is_area,
                                 object: r_item.other_object,
                                 other_idx: r_item.other_shape_index,
                                 self_idx: r_item.self_shape_index,
                                 count: CNT_W'(1)};
                obj_we = 1'b1;
                if (i_obj_stat.hit) begin
                    o_obj_wdata.count = sat_inc(i_obj_stat.hit_entry.count);
                end else begin
                    o_obj_waddr = i_obj_free_addr;
                    o_obj_wdata = '{valid: 1'b1, object: r_item.other_object,
                                    count: CNT_W'(1)};
                end
                n_res.event_res     = EV_ENTER;
                n_res.event_to_area = r_item.other_is_area;
            end
        end else begin
            if (!i_pair_stat.hit) begin
                n_res.status = ST_UNKNOWN;
            end else if (i_pair_stat.hit_entry.count > CNT_W'(1)) begin
                pair_we            = 1'b1;
                o_pair_wdata.count = i_pair_stat.hit_entry.count - CNT_W'(1);
            end else begin
                // last overlap of the pair, shape exited
                pair_we             = 1'b1;
                o_pair_wdata        = '0;
                n_res.event_res     = EV_EXIT;
                n_res.event_to_area = i_pair_stat.hit_entry.is_area;
                if (i_obj_stat.hit) begin
                    obj_we = 1'b1;
                    if (i_obj_stat.hit_entry.count > CNT_W'(1)) begin
                        o_obj_wdata.count = i_obj_stat.hit_entry.count - CNT_W'(1);
                        exit_zero         = 1'b0;
                    end else begin
                        o_obj_wdata = '0;
                    end
                end
                n_res.refresh_body = exit_zero && !i_pair_stat.hit_entry.is_area;
            end
        end
        if (n_res.event_res != EV_NONE) begin
            n_res.event_object      = r_item.other_object;
            n_res.event_other_index = r_item.other_shape_index;
            n_res.event_self_index  = r_item.self_shape_index;
        end
        pair_we = pair_we && load;
        obj_we  = obj_we && load;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item.data;
        end
        if (load) begin
            r_out <= n_res;
        end
    end

    `ORT_ASSERT_HOLDS(a_none_is_blank, i_clk, i_rst_n, r_out_vld && (r_out.event_res == EV_NONE), (r_out.event_object == '0) && (r_out.event_other_index == '0) && (r_out.event_self_index == '0) && !r_out.event_to_area && !r_out.refresh_body, "result without event carries data")
    `ORT_ASSERT_HOLDS(a_refresh_on_exit, i_clk, i_rst_n, r_out_vld && r_out.refresh_body, (r_out.event_res == EV_EXIT) && !r_out.event_to_area, "refresh without body exit")
    `ORT_ASSERT_HOLDS(a_event_status_ok, i_clk, i_rst_n, r_out_vld && (r_out.event_res != EV_NONE), r_out.status == ST_OK, "event reported with error status")
    `ORT_ASSERT_HOLDS(a_no_write_in_scan, i_clk, i_rst_n, r_state != S_WRITE, !pair_we && !obj_we, "table write outside write-back")
    `ORT_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, accept, r_state == S_SCAN, "accepted item did not start a scan")

endmodule

### hdl/overlap_refcount_event_tracker.sv
// Top level of the overlap tracker: sequencer plus pair and object tables.
// Depends on ort_pkg, ort_chan_if, ort_pair_tbl, ort_obj_tbl and ort_ctrl.
`timescale 1ns / 1ps

// Reference-counted enter/exit tracker. Each item on i_item adds or removes one
// overlap of a (object, other shape, self shape) pair and yields exactly one result
// on o_res: an entered or exited event, an override-refresh flag for a body that lost
// its last overlap, and a status. After reset both tables are swept clear, one entry
// per cycle, with i_item.ready low. Items are handled one at a time, each waiting on
// the linear scans, each through the single read port of its table; the pair table
// scan runs alongside the object table scan. A finished result waits in the output
// register while the next item is taken.
module overlap_refcount_event_tracker #(
    parameter int unsigned PAIR_SLOTS   = ort_pkg::PAIR_SLOTS_DEF,
    parameter int unsigned OBJECT_SLOTS = ort_pkg::OBJECT_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ort_chan_if.sink   i_item,
    ort_chan_if.source o_res
);
    import ort_pkg::*;

    localparam int unsigned PAW = $clog2(PAIR_SLOTS);
    localparam int unsigned OAW = $clog2(OBJECT_SLOTS);

    t_item       key;
    t_tbl_cmd    pair_cmd;
    t_tbl_cmd    obj_cmd;
    t_pair_entry pair_wdata;
    t_obj_entry  obj_wdata;
    t_pair_stat  pair_stat;
    t_obj_stat   obj_stat;
    logic [PAW-1:0] pair_waddr;
    logic [PAW-1:0] pair_hit_addr;
    logic [PAW-1:0] pair_free_addr;
    logic [OAW-1:0] obj_waddr;
    logic [OAW-1:0] obj_hit_addr;
    logic [OAW-1:0] obj_free_addr;

    ort_pair_tbl #(.SLOTS(PAIR_SLOTS)) u_pair_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pair_cmd),
        .i_key       (key),
        .i_waddr     (pair_waddr),
        .i_wdata     (pair_wdata),
        .o_stat      (pair_stat),
        .o_hit_addr  (pair_hit_addr),
        .o_free_addr (pair_free_addr)
    );

    ort_obj_tbl #(.SLOTS(OBJECT_SLOTS)) u_obj_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (obj_cmd),
        .i_key       (key),
        .i_waddr     (obj_waddr),
        .i_wdata     (obj_wdata),
        .o_stat      (obj_stat),
        .o_hit_addr  (obj_hit_addr),
        .o_free_addr (obj_free_addr)
    );

    ort_ctrl #(
        .PAIR_SLOTS   (PAIR_SLOTS),
        .OBJECT_SLOTS (OBJECT_SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (i_item),
        .o_res            (o_res),
        .o_key            (key),
        .o_pair_cmd       (pair_cmd),
        .o_pair_waddr     (pair_waddr),
        .o_pair_wdata     (pair_wdata),
        .i_pair_stat      (pair_stat),
        .i_pair_hit_addr  (pair_hit_addr),
        .i_pair_free_addr (pair_free_addr),
        .o_obj_cmd        (obj_cmd),
        .o_obj_waddr      (obj_waddr),
        .o_obj_wdata      (obj_wdata),
        .i_obj_stat       (obj_stat),
        .i_obj_hit_addr   (obj_hit_addr),
        .i_obj_free_addr  (obj_free_addr)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for overlap_refcount_event_tracker (pair/object reference counting).
// Depends on ort_pkg and ort_chan_if; an in-bench predictor mirrors both tables and checks results.
`timescale 1ns / 1ps

module tb_top;
    import ort_pkg::*;

    localparam int PAIR_N       = PAIR_SLOTS_DEF;
    localparam int OBJ_N        = OBJECT_SLOTS_DEF;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 111;
    localparam int MAX_PRINTS   = 40;
    localparam int N_ROWS       = 28;

    // How a repeated directed row walks its key
    typedef enum logic [1:0] {STEP_NONE, STEP_OBJ, STEP_SELF} t_step;

    typedef struct {
        logic             op;
        logic [OBJ_W-1:0] obj;
        logic             area;
        logic [IDX_W-1:0] oi;
        logic [IDX_W-1:0] si;
        int               reps;
        t_step            step;
        bit               pinned;
        t_result          want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ort_chan_if #(.T(t_item))   item_ch ();
    ort_chan_if #(.T(t_result)) res_ch ();

    overlap_refcount_event_tracker #(
        .PAIR_SLOTS   (PAIR_N),
        .OBJECT_SLOTS (OBJ_N)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copies of the block's tables
    t_pair_entry pair_shadow [PAIR_N];
    t_obj_entry  object_shadow [OBJ_N];
    t_result     expected_events [$];

    int fail_count   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit idle_free    = 1'b0;
    bit sink_free    = 1'b0;

    t_stim_row dir_rows [N_ROWS];

    // Result of one overlap change; updates the shadow tables
    function automatic t_result predict_overlap_event(input t_item it);
        t_result r;
        int      i;
        int      p;
        int      np;
        int      o;
        int      no;
        logic    stored_area;
        logic    zero;
        r  = '0;
        p  = -1;
        np = -1;
        o  = -1;
        no = -1;
        for (i = 0; i < PAIR_N; i++) begin
            if (p < 0 && pair_shadow[i].valid && pair_shadow[i].object == it.other_object &&
                pair_shadow[i].other_idx == it.other_shape_index &&
                pair_shadow[i].self_idx == it.self_shape_index)
                p = i;
            if (np < 0 && !pair_shadow[i].valid)
                np = i;
        end
        for (i = 0; i < OBJ_N; i++) begin
            if (o < 0 && object_shadow[i].valid && object_shadow[i].object == it.other_object)
                o = i;
            if (no < 0 && !object_shadow[i].valid)
                no = i;
        end
        if (o >= 0)
            no = o;

        if (it.op == OP_ADD) begin
            if (p >= 0) begin
                // known pair: type is rewritten, count saturates
                pair_shadow[p].is_area = it.other_is_area;
                if (pair_shadow[p].count != CNT_MAX)
                    pair_shadow[p].count = pair_shadow[p].count + 8'd1;
            end else if (np < 0) begin
                r.status = ST_PAIR_FULL;
            end else if (no < 0) begin
                r.status = ST_OBJ_FULL;
            end else begin
                pair_shadow[np] = '{valid: 1'b1, is_area: it.other_is_area,
                                    object: it.other_object, other_idx: it.other_shape_index,
                                    self_idx: it.self_shape_index, count: 8'd1};
                if (o < 0)
                    object_shadow[no] = '{valid: 1'b1, object: it.other_object, count: 8'd1};
                else if (object_shadow[no].count != CNT_MAX)
                    object_shadow[no].count = object_shadow[no].count + 8'd1;
                r.event_res     = EV_ENTER;
                r.event_to_area = it.other_is_area;
            end
        end else begin
            if (p < 0) begin
                r.status = ST_UNKNOWN;
            end else if (pair_shadow[p].count > 8'd1) begin
                pair_shadow[p].count = pair_shadow[p].count - 8'd1;
            end else begin
                // last overlap of the pair: exit, routed by the stored type
                stored_area    = pair_shadow[p].is_area;
                pair_shadow[p] = '0;
                zero           = 1'b1;
                r.event_res     = EV_EXIT;
                r.event_to_area = stored_area;
                if (o >= 0) begin
                    if (object_shadow[o].count > 8'd1) begin
                        object_shadow[o].count = object_shadow[o].count - 8'd1;
                        zero = 1'b0;
                    end else begin
                        object_shadow[o] = '0;
                    end
                end
                r.refresh_body = zero && !stored_area;
            end
        end
        if (r.event_res != EV_NONE) begin
            r.event_object      = it.other_object;
            r.event_other_index = it.other_shape_index;
            r.event_self_index  = it.self_shape_index;
        end
        return r;
    endfunction

    function automatic t_result res_of(input logic [1:0] ev, input logic to_area,
                                       input logic [OBJ_W-1:0] obj,
                                       input logic [IDX_W-1:0] oi, input logic [IDX_W-1:0] si,
                                       input logic refresh, input logic [1:0] st);
        return '{event_res: ev, event_to_area: to_area, event_object: obj,
                 event_other_index: oi, event_self_index: si, refresh_body: refresh, status: st};
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input logic [15:0] got,
                                 input logic [15:0] wanted);
        if (got !== wanted)
            report_mismatch($sformatf("%s is %h, expected %h", what, got, wanted));
    endtask

    // One item transfer; pinned rows carry a hand-written expectation
    task automatic send_item(input t_item it, input bit pinned, input t_result pinned_res);
        t_result want;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (idle_free)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(20, 80);
            else
                gap = $urandom_range(0, 5);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        want = predict_overlap_event(it);
        if (pinned)
            want = pinned_res;
        expected_events.push_back(want);
    endtask

    // Result receiver: random stalls, quiet in some phases
    initial begin
        int stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if (!sink_free && $urandom_range(0, 9) == 0)
                    stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100)
                                                             : $urandom_range(1, 8);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
                report_mismatch("result with no transfer pending");
            end else begin
                want = expected_events.pop_front();
                compare_field("event_res", 16'(res_ch.data.event_res), 16'(want.event_res));
                compare_field("event_to_area", 16'(res_ch.data.event_to_area),
                              16'(want.event_to_area));
                compare_field("event_object", res_ch.data.event_object, want.event_object);
                compare_field("event_other_index", 16'(res_ch.data.event_other_index),
                              16'(want.event_other_index));
                compare_field("event_self_index", 16'(res_ch.data.event_self_index),
                              16'(want.event_self_index));
                compare_field("refresh_body", 16'(res_ch.data.refresh_body),
                              16'(want.refresh_body));
                compare_field("status", 16'(res_ch.data.status), 16'(want.status));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_item            it;
        int               row;
        int               rep;
        int               ph;
        int               n;
        int               i;
        int               pick;
        int               add_pct;
        int               obj_n;
        int               oi_n;
        int               si_n;
        int               live [$];
        logic [OBJ_W-1:0] obj_pool [40];
        logic [IDX_W-1:0] oi_pool [4];
        logic [IDX_W-1:0] si_pool [4];

        i_rst_n       <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        for (i = 0; i < PAIR_N; i++)
            pair_shadow[i] = '0;
        for (i = 0; i < OBJ_N; i++)
            object_shadow[i] = '0;

        // Directed rows: extremes, type rewrite, saturation, both full tables
        dir_rows = '{
            '{OP_REMOVE, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_UNKNOWN)},
            '{OP_ADD, 16'h0000, 1'b0, 8'h00, 8'h00, 1, STEP_NONE, 1'b1,
              res_of(EV_ENTER, 0, 16'h0000, 8'h00, 8'h00, 0, ST_OK)},
            '{OP_ADD, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1, STEP_NONE, 1'b1,
              res_of(EV_ENTER, 1, 16'hFFFF, 8'hFF, 8'hFF, 0, ST_OK)},
            '{OP_ADD, 16'h0000, 1'b0, 8'h00, 8'h00, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_OK)},
            '{OP_REMOVE, 16'h0000, 1'b0, 8'h00, 8'h00, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_OK)},
            '{OP_REMOVE, 16'h0000, 1'b0, 8'h00, 8'h00, 1, STEP_NONE, 1'b1,
              res_of(EV_EXIT, 0, 16'h0000, 8'h00, 8'h00, 1, ST_OK)},
            // re-add as a body: stored type rewritten
            '{OP_ADD, 16'hFFFF, 1'b0, 8'hFF, 8'hFF, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_OK)},
            '{OP_REMOVE, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_OK)},
            '{OP_REMOVE, 16'hFFFF, 1'b1, 8'hFF, 8'hFF, 1, STEP_NONE, 1'b1,
              res_of(EV_EXIT, 0, 16'hFFFF, 8'hFF, 8'hFF, 1, ST_OK)},
            '{OP_ADD, 16'h5A5A, 1'b1, 8'hA5, 8'h5A, 1, STEP_NONE, 1'b1,
              res_of(EV_ENTER, 1, 16'h5A5A, 8'hA5, 8'h5A, 0, ST_OK)},
            '{OP_REMOVE, 16'hA5A5, 1'b0, 8'h5A, 8'hA5, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_UNKNOWN)},
            '{OP_REMOVE, 16'h5A5A, 1'b0, 8'hA5, 8'h5A, 1, STEP_NONE, 1'b1,
              res_of(EV_EXIT, 1, 16'h5A5A, 8'hA5, 8'h5A, 0, ST_OK)},
            // two pairs on one object
            '{OP_ADD, 16'h1234, 1'b0, 8'h01, 8'h02, 1, STEP_NONE, 1'b0, '0},
            '{OP_ADD, 16'h1234, 1'b1, 8'h03, 8'h04, 1, STEP_NONE, 1'b0, '0},
            '{OP_REMOVE, 16'h1234, 1'b0, 8'h01, 8'h02, 1, STEP_NONE, 1'b0, '0},
            '{OP_REMOVE, 16'h1234, 1'b0, 8'h03, 8'h04, 1, STEP_NONE, 1'b0, '0},
            // pair count saturation and countdown
            '{OP_ADD, 16'h00FF, 1'b0, 8'h0F, 8'hF0, 256, STEP_NONE, 1'b0, '0},
            '{OP_REMOVE, 16'h00FF, 1'b0, 8'h0F, 8'hF0, 255, STEP_NONE, 1'b0, '0},
            // object table full
            '{OP_ADD, 16'h8000, 1'b0, 8'h00, 8'h00, OBJ_N, STEP_OBJ, 1'b0, '0},
            '{OP_ADD, 16'h7000, 1'b1, 8'h00, 8'h00, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_OBJ_FULL)},
            '{OP_ADD, 16'h8000, 1'b1, 8'h01, 8'h00, 1, STEP_NONE, 1'b0, '0},
            // pair table full
            '{OP_ADD, 16'h8001, 1'b0, 8'h07, 8'h01, 31, STEP_SELF, 1'b0, '0},
            '{OP_ADD, 16'h8002, 1'b0, 8'h07, 8'h07, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_PAIR_FULL)},
            '{OP_ADD, 16'h7000, 1'b1, 8'h00, 8'h00, 1, STEP_NONE, 1'b1,
              res_of(EV_NONE, 0, 16'h0000, 8'h00, 8'h00, 0, ST_PAIR_FULL)},
            '{OP_ADD, 16'h8001, 1'b1, 8'h07, 8'h01, 1, STEP_NONE, 1'b0, '0},
            // drain
            '{OP_REMOVE, 16'h8000, 1'b0, 8'h00, 8'h00, OBJ_N, STEP_OBJ, 1'b0, '0},
            '{OP_REMOVE, 16'h8000, 1'b0, 8'h01, 8'h00, 1, STEP_NONE, 1'b0, '0},
            '{OP_REMOVE, 16'h8001, 1'b0, 8'h07, 8'h01, 31, STEP_SELF, 1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++) begin
            for (rep = 0; rep < dir_rows[row].reps; rep++) begin
                it.op                = dir_rows[row].op;
                it.other_object      = dir_rows[row].obj +
                                       OBJ_W'((dir_rows[row].step == STEP_OBJ) ? rep : 0);
                it.other_is_area     = dir_rows[row].area;
                it.other_shape_index = dir_rows[row].oi;
                it.self_shape_index  = dir_rows[row].si +
                                       IDX_W'((dir_rows[row].step == STEP_SELF) ? rep : 0);
                send_item(it, dir_rows[row].pinned, dir_rows[row].want);
            end
        end

        // Random phases: keys from small pools so tables fill, counts climb and pairs exit
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            idle_free = (ph == 2 || ph == 5);
            sink_free = (ph == 3 || ph == 6);
            add_pct   = (ph % 3 == 0) ? 80 : ((ph % 3 == 1) ? 50 : 25);
            obj_n     = (ph % 2 == 0) ? $urandom_range(20, 40) : $urandom_range(2, 8);
            oi_n      = $urandom_range(1, 4);
            si_n      = $urandom_range(1, 4);
            for (i = 0; i < 40; i++)
                obj_pool[i] = OBJ_W'($urandom_range(0, 65535));
            for (i = 0; i < 4; i++) begin
                oi_pool[i] = IDX_W'($urandom_range(0, 255));
                si_pool[i] = IDX_W'($urandom_range(0, 255));
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                it.other_is_area     = 1'($urandom_range(0, 1));
                it.other_object      = obj_pool[$urandom_range(0, obj_n - 1)];
                it.other_shape_index = oi_pool[$urandom_range(0, oi_n - 1)];
                it.self_shape_index  = si_pool[$urandom_range(0, si_n - 1)];
                if (pick < 6) begin
                    // noise: any key, any operation
                    it.op                = 1'($urandom_range(0, 1));
                    it.other_object      = OBJ_W'($urandom_range(0, 65535));
                    it.other_shape_index = IDX_W'($urandom_range(0, 255));
                    it.self_shape_index  = IDX_W'($urandom_range(0, 255));
                end else if (pick < 6 + add_pct * 94 / 100) begin
                    it.op = OP_ADD;
                end else begin
                    it.op = OP_REMOVE;
                    live.delete();
                    for (i = 0; i < PAIR_N; i++)
                        if (pair_shadow[i].valid)
                            live.push_back(i);
                    // mostly a live pair; sometimes a pool key that may be unknown
                    if (live.size() != 0 && $urandom_range(0, 9) != 0) begin
                        i = live[$urandom_range(0, live.size() - 1)];
                        it.other_object      = pair_shadow[i].object;
                        it.other_shape_index = pair_shadow[i].other_idx;
                        it.self_shape_index  = pair_shadow[i].self_idx;
                    end
                end
                send_item(it, 1'b0, '0);
            end
        end

        item_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
